### hw/rtl/emgf_pkg.sv
// Shared types and constants of the EMG envelope filter.
// Used by the controller, datapath, divider and top level; no dependencies.
package emgf_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int ENV_BITS         = SAMPLE_BITS + 1;
    localparam int V_BITS           = SAMPLE_BITS + 2;
    localparam int MAX_LOWPASS_LEN  = 16;
    localparam int MAX_HIGHPASS_LEN = 256;
    localparam int MAX_ENVELOPE_LEN = 1024;

    localparam int LP_LEN_BITS  = 5;
    localparam int HP_LEN_BITS  = 9;
    localparam int ENV_LEN_BITS = 11;
    localparam int LP_POS_BITS  = $clog2(MAX_LOWPASS_LEN);
    localparam int HP_POS_BITS  = $clog2(MAX_HIGHPASS_LEN);
    localparam int ENV_POS_BITS = $clog2(MAX_ENVELOPE_LEN);

    localparam int LP_SUM_BITS  = 20;
    localparam int HP_SUM_BITS  = 25;
    localparam int ENV_SUM_BITS = 27;

    localparam int HP_RESET_LEN  = 100;
    localparam int ENV_RESET_LEN = 500;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 11;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGHPASS_ENABLE = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_REFERENCE_MODE  = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOWPASS_LENGTH  = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGHPASS_LENGTH = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENVELOPE_LENGTH = CFG_INDEX_BITS'(4);

    // divider: two quotient bits per cycle
    localparam int DIV_W         = 28;
    localparam int Q_BITS        = V_BITS;
    localparam int DIV_STEP_BITS = 4;
    localparam int LP_DIV_STEPS  = 10;
    localparam int HP_DIV_STEPS  = 12;
    localparam int ENV_DIV_STEPS = 14;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LP_UPD,
        S_LP_START,
        S_LP_WAIT,
        S_REF_START,
        S_REF_WAIT,
        S_HP_UPD,
        S_HP_START,
        S_HP_WAIT,
        S_ENV_UPD,
        S_ENV_START,
        S_ENV_WAIT
    } t_state;

    typedef enum logic [1:0] {
        AVG_LP,
        AVG_REF,
        AVG_HP,
        AVG_ENV
    } t_avg_sel;

    typedef struct packed {
        logic     load;
        logic     lp_upd;
        logic     hp_upd;
        logic     env_upd;
        logic     div_start;
        logic     capture;
        t_avg_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic highpass_enable;
        logic reference_mode;
    } t_dp_status;

endpackage

### hw/rtl/emgf_div.sv
// Shared serial divider: signed dividend by positive window length, truncating.
// Restoring, two quotient bits per cycle. Depends on emgf_pkg.
module emgf_div (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_start,
    input  logic signed [emgf_pkg::DIV_W-1:0]           i_dividend,
    input  logic        [emgf_pkg::ENV_LEN_BITS-1:0]    i_divisor,
    input  logic        [emgf_pkg::DIV_STEP_BITS-1:0]   i_steps,
    output logic                                        o_busy,
    output logic signed [emgf_pkg::Q_BITS-1:0]          o_quotient
);

    localparam int W     = emgf_pkg::DIV_W;
    localparam int DB    = emgf_pkg::ENV_LEN_BITS;
    localparam int SB    = $clog2(W + 1);
    localparam int Q_MAG = emgf_pkg::Q_BITS - 1;

    logic                              r_busy;
    logic [emgf_pkg::DIV_STEP_BITS-1:0] r_cnt;
    logic [W-1:0]                      r_q;
    logic [DB-1:0]                     r_rem;
    logic [DB-1:0]                     r_divisor;
    logic                              r_neg;

    logic [W-1:0]    w_mag;
    logic [SB-1:0]   w_shamt;
    logic [DB:0]     w_t1;
    logic [DB:0]     w_t2;
    logic [DB-1:0]   w_rem1;
    logic [DB-1:0]   n_rem;
    logic            w_b1;
    logic            w_b2;
    logic [W-1:0]    n_q;
    logic [Q_MAG-1:0] w_qmag;

    always_comb begin
        w_mag   = i_dividend[W-1] ? W'(-i_dividend) : W'(i_dividend);
        w_shamt = SB'(W) - SB'({i_steps, 1'b0});

        w_t1 = {r_rem, r_q[W-1]};
        if (w_t1 >= {1'b0, r_divisor}) begin
            w_b1   = 1'b1;
            w_rem1 = DB'(w_t1 - {1'b0, r_divisor});
        end else begin
            w_b1   = 1'b0;
            w_rem1 = w_t1[DB-1:0];
        end

        w_t2 = {w_rem1, r_q[W-2]};
        if (w_t2 >= {1'b0, r_divisor}) begin
            w_b2  = 1'b1;
            n_rem = DB'(w_t2 - {1'b0, r_divisor});
        end else begin
            w_b2  = 1'b0;
            n_rem = w_t2[DB-1:0];
        end

        n_q    = {r_q[W-3:0], w_b1, w_b2};
        w_qmag = r_q[Q_MAG-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == emgf_pkg::DIV_STEP_BITS'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q       <= w_mag << w_shamt;
            r_rem     <= '0;
            r_divisor <= i_divisor;
            r_neg     <= i_dividend[W-1];
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? -$signed({1'b0, w_qmag}) : $signed({1'b0, w_qmag});

endmodule

### hw/rtl/emgf_datapath.sv
// Datapath: configuration registers, the four moving-average rings and sums,
// working value and result register. Depends on emgf_pkg and emgf_div.
module emgf_datapath (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_wr_en,
    input  logic        [emgf_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic        [emgf_pkg::CFG_DATA_BITS-1:0]   i_cfg_wr_data,
    input  logic signed [emgf_pkg::SAMPLE_BITS-1:0]     i_sample,
    input  logic signed [emgf_pkg::SAMPLE_BITS-1:0]     i_reference_sample,
    input  emgf_pkg::t_dp_cmd                           i_cmd,
    output emgf_pkg::t_dp_status                        o_status,
    output logic        [emgf_pkg::ENV_BITS-1:0]        o_envelope
);

    localparam int SW  = emgf_pkg::SAMPLE_BITS;
    localparam int EW  = emgf_pkg::ENV_BITS;
    localparam int VW  = emgf_pkg::V_BITS;
    localparam int HW  = emgf_pkg::ENV_BITS;
    localparam int LSB = emgf_pkg::LP_SUM_BITS;
    localparam int HSB = emgf_pkg::HP_SUM_BITS;
    localparam int ESB = emgf_pkg::ENV_SUM_BITS;
    localparam int LLB = emgf_pkg::LP_LEN_BITS;
    localparam int HLB = emgf_pkg::HP_LEN_BITS;
    localparam int ELB = emgf_pkg::ENV_LEN_BITS;
    localparam int LPB = emgf_pkg::LP_POS_BITS;
    localparam int HPB = emgf_pkg::HP_POS_BITS;
    localparam int EPB = emgf_pkg::ENV_POS_BITS;

    // configuration
    logic           r_highpass_enable;
    logic           r_reference_mode;
    logic [LLB-1:0] r_lp_len;
    logic [HLB-1:0] r_hp_len;
    logic [ELB-1:0] r_env_len;
    logic [LLB-1:0] w_lp_len_wr;
    logic [HLB-1:0] w_hp_len_wr;
    logic [ELB-1:0] w_env_len_wr;
    logic           w_lp_clr;
    logic           w_hp_clr;
    logic           w_env_clr;

    // ring memories
    logic signed [SW-1:0] r_lp_mem  [emgf_pkg::MAX_LOWPASS_LEN];
    logic signed [SW-1:0] r_ref_mem [emgf_pkg::MAX_LOWPASS_LEN];
    logic signed [HW-1:0] r_hp_mem  [emgf_pkg::MAX_HIGHPASS_LEN];
    logic        [EW-1:0] r_env_mem [emgf_pkg::MAX_ENVELOPE_LEN];
    logic signed [SW-1:0] r_lp_rd;
    logic signed [SW-1:0] r_ref_rd;
    logic signed [HW-1:0] r_hp_rd;
    logic        [EW-1:0] r_env_rd;

    // ring state
    logic [LPB-1:0]        r_lp_pos;
    logic [LPB-1:0]        r_ref_pos;
    logic [HPB-1:0]        r_hp_pos;
    logic [EPB-1:0]        r_env_pos;
    logic                  r_lp_wrap;
    logic                  r_ref_wrap;
    logic                  r_hp_wrap;
    logic                  r_env_wrap;
    logic signed [LSB-1:0] r_lp_sum;
    logic signed [LSB-1:0] r_ref_sum;
    logic signed [HSB-1:0] r_hp_sum;
    logic        [ESB-1:0] r_env_sum;

    // working values
    logic signed [SW-1:0] r_x;
    logic signed [SW-1:0] r_r;
    logic signed [VW-1:0] r_v;
    logic        [EW-1:0] r_env;

    logic signed [SW-1:0]  w_lp_old;
    logic signed [SW-1:0]  w_ref_old;
    logic signed [HW-1:0]  w_hp_old;
    logic        [EW-1:0]  w_env_old;
    logic signed [LSB-1:0] n_lp_sum;
    logic signed [LSB-1:0] n_ref_sum;
    logic signed [HSB-1:0] n_hp_sum;
    logic        [ESB-1:0] n_env_sum;
    logic        [LLB-1:0] w_lp_inc;
    logic        [LLB-1:0] w_ref_inc;
    logic        [HLB-1:0] w_hp_inc;
    logic        [ELB-1:0] w_env_inc;
    logic                  w_lp_end;
    logic                  w_ref_end;
    logic                  w_hp_end;
    logic                  w_env_end;
    logic signed [HW-1:0]  w_v_narrow;
    logic signed [VW-1:0]  w_v_abs;
    logic        [EW-1:0]  w_rect;

    logic signed [emgf_pkg::DIV_W-1:0]         w_div_dividend;
    logic        [ELB-1:0]                     w_div_divisor;
    logic        [emgf_pkg::DIV_STEP_BITS-1:0] w_div_steps;
    logic                                      w_div_busy;
    logic signed [emgf_pkg::Q_BITS-1:0]        w_div_q;

    // length writes: zero reads as one, above maximum reads as maximum
    always_comb begin
        w_lp_len_wr  = i_cfg_wr_data[LLB-1:0];
        w_hp_len_wr  = i_cfg_wr_data[HLB-1:0];
        w_env_len_wr = i_cfg_wr_data[ELB-1:0];
        if (w_lp_len_wr == '0) begin
            w_lp_len_wr = LLB'(1);
        end else if (w_lp_len_wr > LLB'(emgf_pkg::MAX_LOWPASS_LEN)) begin
            w_lp_len_wr = LLB'(emgf_pkg::MAX_LOWPASS_LEN);
        end
        if (w_hp_len_wr == '0) begin
            w_hp_len_wr = HLB'(1);
        end else if (w_hp_len_wr > HLB'(emgf_pkg::MAX_HIGHPASS_LEN)) begin
            w_hp_len_wr = HLB'(emgf_pkg::MAX_HIGHPASS_LEN);
        end
        if (w_env_len_wr == '0) begin
            w_env_len_wr = ELB'(1);
        end else if (w_env_len_wr > ELB'(emgf_pkg::MAX_ENVELOPE_LEN)) begin
            w_env_len_wr = ELB'(emgf_pkg::MAX_ENVELOPE_LEN);
        end
        w_lp_clr  = i_cfg_wr_en && (i_cfg_index == emgf_pkg::REG_LOWPASS_LENGTH);
        w_hp_clr  = i_cfg_wr_en && (i_cfg_index == emgf_pkg::REG_HIGHPASS_LENGTH);
        w_env_clr = i_cfg_wr_en && (i_cfg_index == emgf_pkg::REG_ENVELOPE_LENGTH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highpass_enable <= 1'b1;
            r_reference_mode  <= 1'b0;
            r_lp_len          <= LLB'(1);
            r_hp_len          <= HLB'(emgf_pkg::HP_RESET_LEN);
            r_env_len         <= ELB'(emgf_pkg::ENV_RESET_LEN);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                emgf_pkg::REG_HIGHPASS_ENABLE: r_highpass_enable <= i_cfg_wr_data[0];
                emgf_pkg::REG_REFERENCE_MODE:  r_reference_mode  <= i_cfg_wr_data[0];
                emgf_pkg::REG_LOWPASS_LENGTH:  r_lp_len          <= w_lp_len_wr;
                emgf_pkg::REG_HIGHPASS_LENGTH: r_hp_len          <= w_hp_len_wr;
                emgf_pkg::REG_ENVELOPE_LENGTH: r_env_len         <= w_env_len_wr;
                default: ;
            endcase
        end
    end

    // an entry not yet written since the last clear reads as zero
    always_comb begin
        w_lp_old  = r_lp_wrap  ? r_lp_rd  : '0;
        w_ref_old = r_ref_wrap ? r_ref_rd : '0;
        w_hp_old  = r_hp_wrap  ? r_hp_rd  : '0;
        w_env_old = r_env_wrap ? r_env_rd : '0;

        w_v_narrow = r_v[HW-1:0];
        w_v_abs    = r_v[VW-1] ? -r_v : r_v;
        w_rect     = w_v_abs[EW-1:0];

        n_lp_sum  = r_lp_sum + LSB'(r_x) - LSB'(w_lp_old);
        n_ref_sum = r_ref_sum + LSB'(r_r) - LSB'(w_ref_old);
        n_hp_sum  = r_hp_sum + HSB'(w_v_narrow) - HSB'(w_hp_old);
        n_env_sum = r_env_sum + ESB'(w_rect) - ESB'(w_env_old);

        w_lp_inc  = {1'b0, r_lp_pos} + LLB'(1);
        w_ref_inc = {1'b0, r_ref_pos} + LLB'(1);
        w_hp_inc  = {1'b0, r_hp_pos} + HLB'(1);
        w_env_inc = {1'b0, r_env_pos} + ELB'(1);
        w_lp_end  = (w_lp_inc == r_lp_len);
        w_ref_end = (w_ref_inc == r_lp_len);
        w_hp_end  = (w_hp_inc == r_hp_len);
        w_env_end = (w_env_inc == r_env_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_lp_clr) begin
            r_lp_pos   <= '0;
            r_ref_pos  <= '0;
            r_lp_wrap  <= 1'b0;
            r_ref_wrap <= 1'b0;
            r_lp_sum   <= '0;
            r_ref_sum  <= '0;
        end else if (i_cmd.lp_upd) begin
            r_lp_sum <= n_lp_sum;
            r_lp_pos <= w_lp_end ? '0 : w_lp_inc[LPB-1:0];
            if (w_lp_end) begin
                r_lp_wrap <= 1'b1;
            end
            if (r_reference_mode) begin
                r_ref_sum <= n_ref_sum;
                r_ref_pos <= w_ref_end ? '0 : w_ref_inc[LPB-1:0];
                if (w_ref_end) begin
                    r_ref_wrap <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_hp_clr) begin
            r_hp_pos  <= '0;
            r_hp_wrap <= 1'b0;
            r_hp_sum  <= '0;
        end else if (i_cmd.hp_upd) begin
            r_hp_sum <= n_hp_sum;
            r_hp_pos <= w_hp_end ? '0 : w_hp_inc[HPB-1:0];
            if (w_hp_end) begin
                r_hp_wrap <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_env_clr) begin
            r_env_pos  <= '0;
            r_env_wrap <= 1'b0;
            r_env_sum  <= '0;
        end else if (i_cmd.env_upd) begin
            r_env_sum <= n_env_sum;
            r_env_pos <= w_env_end ? '0 : w_env_inc[EPB-1:0];
            if (w_env_end) begin
                r_env_wrap <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lp_upd) begin
            r_lp_mem[r_lp_pos] <= r_x;
        end
        if (i_cmd.load) begin
            r_lp_rd <= r_lp_mem[r_lp_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lp_upd && r_reference_mode) begin
            r_ref_mem[r_ref_pos] <= r_r;
        end
        if (i_cmd.load) begin
            r_ref_rd <= r_ref_mem[r_ref_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hp_upd) begin
            r_hp_mem[r_hp_pos] <= w_v_narrow;
        end
        if (i_cmd.load) begin
            r_hp_rd <= r_hp_mem[r_hp_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.env_upd) begin
            r_env_mem[r_env_pos] <= w_rect;
        end
        if (i_cmd.load) begin
            r_env_rd <= r_env_mem[r_env_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x <= i_sample;
            r_r <= i_reference_sample;
        end
        if (i_cmd.capture) begin
            case (i_cmd.sel)
                emgf_pkg::AVG_LP:  r_v   <= w_div_q;
                emgf_pkg::AVG_REF: r_v   <= r_v - w_div_q;
                emgf_pkg::AVG_HP:  r_v   <= r_v - w_div_q;
                emgf_pkg::AVG_ENV: r_env <= w_div_q[EW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.sel)
            emgf_pkg::AVG_LP: begin
                w_div_dividend = emgf_pkg::DIV_W'(r_lp_sum);
                w_div_divisor  = ELB'(r_lp_len);
                w_div_steps    = emgf_pkg::DIV_STEP_BITS'(emgf_pkg::LP_DIV_STEPS);
            end
            emgf_pkg::AVG_REF: begin
                w_div_dividend = emgf_pkg::DIV_W'(r_ref_sum);
                w_div_divisor  = ELB'(r_lp_len);
                w_div_steps    = emgf_pkg::DIV_STEP_BITS'(emgf_pkg::LP_DIV_STEPS);
            end
            emgf_pkg::AVG_HP: begin
                w_div_dividend = emgf_pkg::DIV_W'(r_hp_sum);
                w_div_divisor  = ELB'(r_hp_len);
                w_div_steps    = emgf_pkg::DIV_STEP_BITS'(emgf_pkg::HP_DIV_STEPS);
            end
            default: begin
                w_div_dividend = emgf_pkg::DIV_W'(r_env_sum);
                w_div_divisor  = r_env_len;
                w_div_steps    = emgf_pkg::DIV_STEP_BITS'(emgf_pkg::ENV_DIV_STEPS);
            end
        endcase
    end

    emgf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .i_steps    (w_div_steps),
        .o_busy     (w_div_busy),
        .o_quotient (w_div_q)
    );

    assign o_status.div_busy        = w_div_busy;
    assign o_status.highpass_enable = r_highpass_enable;
    assign o_status.reference_mode  = r_reference_mode;
    assign o_envelope               = r_env;

endmodule

### hw/rtl/emgf_ctrl.sv
// Controller: sequences the averages of one sample and owns both handshakes.
// Depends on emgf_pkg.
module emgf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    input  emgf_pkg::t_dp_status i_status,
    output emgf_pkg::t_dp_cmd    o_cmd
);

    emgf_pkg::t_state r_state;
    emgf_pkg::t_state n_state;
    logic             r_out_valid;
    logic             w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            emgf_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = emgf_pkg::S_LP_UPD;
                end
            end
            emgf_pkg::S_LP_UPD:   n_state = emgf_pkg::S_LP_START;
            emgf_pkg::S_LP_START: n_state = emgf_pkg::S_LP_WAIT;
            emgf_pkg::S_LP_WAIT: begin
                if (!i_status.div_busy) begin
                    if (i_status.reference_mode) begin
                        n_state = emgf_pkg::S_REF_START;
                    end else if (i_status.highpass_enable) begin
                        n_state = emgf_pkg::S_HP_UPD;
                    end else begin
                        n_state = emgf_pkg::S_ENV_UPD;
                    end
                end
            end
            emgf_pkg::S_REF_START: n_state = emgf_pkg::S_REF_WAIT;
            emgf_pkg::S_REF_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = i_status.highpass_enable ? emgf_pkg::S_HP_UPD
                                                       : emgf_pkg::S_ENV_UPD;
                end
            end
            emgf_pkg::S_HP_UPD:   n_state = emgf_pkg::S_HP_START;
            emgf_pkg::S_HP_START: n_state = emgf_pkg::S_HP_WAIT;
            emgf_pkg::S_HP_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = emgf_pkg::S_ENV_UPD;
                end
            end
            emgf_pkg::S_ENV_UPD:   n_state = emgf_pkg::S_ENV_START;
            emgf_pkg::S_ENV_START: n_state = emgf_pkg::S_ENV_WAIT;
            emgf_pkg::S_ENV_WAIT: begin
                if (!i_status.div_busy && w_out_free) begin
                    n_state = emgf_pkg::S_IDLE;
                end
            end
            default: n_state = emgf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            emgf_pkg::S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            emgf_pkg::S_LP_UPD: o_cmd.lp_upd = 1'b1;
            emgf_pkg::S_LP_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.sel       = emgf_pkg::AVG_LP;
            end
            emgf_pkg::S_LP_WAIT: begin
                o_cmd.capture = !i_status.div_busy;
                o_cmd.sel     = emgf_pkg::AVG_LP;
            end
            emgf_pkg::S_REF_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.sel       = emgf_pkg::AVG_REF;
            end
            emgf_pkg::S_REF_WAIT: begin
                o_cmd.capture = !i_status.div_busy;
                o_cmd.sel     = emgf_pkg::AVG_REF;
            end
            emgf_pkg::S_HP_UPD: o_cmd.hp_upd = 1'b1;
            emgf_pkg::S_HP_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.sel       = emgf_pkg::AVG_HP;
            end
            emgf_pkg::S_HP_WAIT: begin
                o_cmd.capture = !i_status.div_busy;
                o_cmd.sel     = emgf_pkg::AVG_HP;
            end
            emgf_pkg::S_ENV_UPD: o_cmd.env_upd = 1'b1;
            emgf_pkg::S_ENV_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.sel       = emgf_pkg::AVG_ENV;
            end
            emgf_pkg::S_ENV_WAIT: begin
                o_cmd.capture = !i_status.div_busy && w_out_free;
                o_cmd.sel     = emgf_pkg::AVG_ENV;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= emgf_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == emgf_pkg::S_ENV_WAIT && !i_status.div_busy && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

### hw/rtl/emg_envelope_filter.sv
// EMG envelope filter top level: controller plus datapath.
// Depends on emgf_pkg, emgf_ctrl, emgf_datapath (with emgf_div).
//
// One envelope value per accepted sample. Each sample runs through up to four
// moving averages in turn (low-pass, reference low-pass, high-pass baseline,
// envelope), all sharing one serial divider that retires two quotient bits a
// cycle. The reference low-pass runs only in reference mode and the high-pass
// baseline only with high-pass enabled. The next sample is taken the cycle
// after the result is registered, so a sample is not taken before the last
// one is through. A waiting result does not block the next sample, but that
// sample's result waits until the output is free. Writing a length register
// restarts the averages that use it from zero at once; no clearing pass runs
// after reset. Write configuration only while no sample is in flight.
module emg_envelope_filter (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_wr_en,
    input  logic        [emgf_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic        [emgf_pkg::CFG_DATA_BITS-1:0]   i_cfg_wr_data,
    input  logic                                        i_valid,
    output logic                                        o_stall,
    input  logic signed [emgf_pkg::SAMPLE_BITS-1:0]     i_sample,
    input  logic signed [emgf_pkg::SAMPLE_BITS-1:0]     i_reference_sample,
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output logic        [emgf_pkg::ENV_BITS-1:0]        o_envelope
);

    emgf_pkg::t_dp_cmd    w_cmd;
    emgf_pkg::t_dp_status w_status;

    emgf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    emgf_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_sample           (i_sample),
        .i_reference_sample (i_reference_sample),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .o_envelope         (o_envelope)
    );

endmodule

### tb/sv/tb_emg_envelope_filter.sv
// Self-checking testbench for emg_envelope_filter: directed and random samples,
// predicted envelopes compared per transfer. Depends on emgf_pkg and the RTL.
module tb_emg_envelope_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import emgf_pkg::*;

    localparam int ITEM_LATENCY  = 64;
    localparam int PHASE_ITEMS   = 125;
    localparam int RANDOM_PHASES = 12;
    localparam int MAX_REPORTS   = 10;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]      i_cfg_wr_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic signed [SAMPLE_BITS-1:0] i_reference_sample = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [ENV_BITS-1:0]           o_envelope;

    emg_envelope_filter u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_sample           (i_sample),
        .i_reference_sample (i_reference_sample),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_envelope         (o_envelope)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // filter state mirror
    logic        hp_en;
    logic        ref_mode;
    int unsigned lp_len;
    int unsigned hp_len;
    int unsigned env_len;
    int          ring_mem [4][MAX_ENVELOPE_LEN];
    longint      ring_sum [4];
    int unsigned ring_pos [4];

    logic [ENV_BITS-1:0] pending_envelopes [$];
    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int                            burst_left = 0;
    logic signed [SAMPLE_BITS-1:0] burst_val  = '0;

    function automatic int unsigned clamp_len(int unsigned v, int unsigned max_len);
        if (v == 0) return 1;
        if (v > max_len) return max_len;
        return v;
    endfunction

    function automatic void window_clear(t_avg_sel sel);
        for (int i = 0; i < MAX_ENVELOPE_LEN; i++) ring_mem[sel][i] = 0;
        ring_sum[sel] = 0;
        ring_pos[sel] = 0;
    endfunction

    function automatic longint window_push(t_avg_sel sel, int unsigned len, longint val);
        int unsigned p;
        p = ring_pos[sel];
        if (p >= len) p = 0;
        ring_sum[sel] += val - longint'(ring_mem[sel][p]);
        ring_mem[sel][p] = int'(val);
        p++;
        if (p >= len) p = 0;
        ring_pos[sel] = p;
        return ring_sum[sel] / longint'(len);
    endfunction

    function automatic void filter_reset();
        hp_en    = 1'b1;
        ref_mode = 1'b0;
        lp_len   = 1;
        hp_len   = HP_RESET_LEN;
        env_len  = ENV_RESET_LEN;
        window_clear(AVG_LP);
        window_clear(AVG_REF);
        window_clear(AVG_HP);
        window_clear(AVG_ENV);
    endfunction

    function automatic void apply_config(logic [CFG_INDEX_BITS-1:0] idx,
                                         logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_HIGHPASS_ENABLE: hp_en = data[0];
            REG_REFERENCE_MODE:  ref_mode = data[0];
            REG_LOWPASS_LENGTH: begin
                lp_len = clamp_len(data[LP_LEN_BITS-1:0], MAX_LOWPASS_LEN);
                window_clear(AVG_LP);
                window_clear(AVG_REF);
            end
            REG_HIGHPASS_LENGTH: begin
                hp_len = clamp_len(data[HP_LEN_BITS-1:0], MAX_HIGHPASS_LEN);
                window_clear(AVG_HP);
            end
            REG_ENVELOPE_LENGTH: begin
                env_len = clamp_len(data[ENV_LEN_BITS-1:0], MAX_ENVELOPE_LEN);
                window_clear(AVG_ENV);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [ENV_BITS-1:0] predict_envelope(
            logic signed [SAMPLE_BITS-1:0] smp, logic signed [SAMPLE_BITS-1:0] rsmp);
        longint v;
        longint base;
        longint rect;
        longint env;
        v = window_push(AVG_LP, lp_len, longint'(smp));
        if (ref_mode) v -= window_push(AVG_REF, lp_len, longint'(rsmp));
        if (hp_en) begin
            base = window_push(AVG_HP, hp_len, v);
            v -= base;
        end
        rect = (v < 0) ? -v : v;
        env = window_push(AVG_ENV, env_len, rect);
        return ENV_BITS'(env);
    endfunction

    task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        apply_config(idx, data);
    endtask

    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] smp,
                               logic signed [SAMPLE_BITS-1:0] rsmp);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid            <= 1'b1;
        i_sample           <= smp;
        i_reference_sample <= rsmp;
        do @(posedge i_clk); while (o_stall);
        pending_envelopes.push_back(predict_envelope(smp, rsmp));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_envelopes.size() != 0) @(posedge i_clk);
        repeat (ITEM_LATENCY) @(posedge i_clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            1:       begin send_idle_pct = 76; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 76; end
            3:       begin send_idle_pct = 23; recv_stall_pct = 23; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    always @(negedge i_clk) i_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_envelopes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected envelope transfer: %0d", o_envelope);
            end else begin
                if (o_envelope !== pending_envelopes[0]) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("envelope mismatch: expected %0d, got %0d",
                                 pending_envelopes[0], o_envelope);
                end
                void'(pending_envelopes.pop_front());
            end
        end
    end

    // extremes held for a while push the envelope toward full scale
    function automatic logic signed [SAMPLE_BITS-1:0] gen_sample();
        if (burst_left > 0) begin
            burst_left--;
            return burst_val;
        end
        case ($urandom_range(19))
            0: begin
                burst_left = $urandom_range(40);
                burst_val  = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                return burst_val;
            end
            1, 2:    return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            3, 4, 5: return SAMPLE_BITS'(int'($urandom_range(255)) - 128);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh0000, 16'shffff);
        send_sample(16'shffff, 16'sh0000);
        send_sample(16'sh7fff, 16'sh5a5a);
        send_sample(16'sh0001, 16'sha5a5);
        wait_idle();
    endtask

    task automatic test_reference_mode();
        cfg_write(REG_REFERENCE_MODE, CFG_DATA_BITS'(1));
        cfg_write(REG_LOWPASS_LENGTH, CFG_DATA_BITS'(MAX_LOWPASS_LEN));
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'shffff, 16'sh8000);
        send_sample(16'sh3039, 16'sh7fff);
        wait_idle();
    endtask

    task automatic test_length_limits();
        cfg_write(REG_LOWPASS_LENGTH, '0);
        cfg_write(REG_HIGHPASS_LENGTH, '1);
        cfg_write(REG_ENVELOPE_LENGTH, '1);
        for (int k = int'(REG_ENVELOPE_LENGTH) + 1; k < 2 ** CFG_INDEX_BITS; k++)
            cfg_write(CFG_INDEX_BITS'(k), '1);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh7fff, 16'sh8000);
        wait_idle();
        cfg_write(REG_LOWPASS_LENGTH, CFG_DATA_BITS'(31));
        cfg_write(REG_HIGHPASS_LENGTH, '0);
        cfg_write(REG_ENVELOPE_LENGTH, '0);
        send_sample(16'sh7fff, 16'sh0000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh1234, 16'sh8000);
        wait_idle();
    endtask

    task automatic test_mode_toggle();
        cfg_write(REG_HIGHPASS_LENGTH, CFG_DATA_BITS'(4));
        cfg_write(REG_HIGHPASS_ENABLE, '0);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        wait_idle();
        cfg_write(REG_REFERENCE_MODE, '0);
        cfg_write(REG_HIGHPASS_ENABLE, CFG_DATA_BITS'(1));
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic signed [SAMPLE_BITS-1:0] smp;
        logic signed [SAMPLE_BITS-1:0] rsmp;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_idling(ph % 4);
            if ($urandom_range(1)) cfg_write(REG_HIGHPASS_ENABLE, CFG_DATA_BITS'($urandom));
            if ($urandom_range(1)) cfg_write(REG_REFERENCE_MODE, CFG_DATA_BITS'($urandom));
            if ($urandom_range(1))
                cfg_write(REG_LOWPASS_LENGTH, CFG_DATA_BITS'($urandom_range(31)));
            if ($urandom_range(1))
                cfg_write(REG_HIGHPASS_LENGTH, CFG_DATA_BITS'(($urandom_range(7) == 0) ?
                          $urandom_range(511) : $urandom_range(1, 12)));
            if ($urandom_range(1))
                cfg_write(REG_ENVELOPE_LENGTH, CFG_DATA_BITS'(($urandom_range(7) == 0) ?
                          $urandom_range(2047) : $urandom_range(1, 24)));
            if ($urandom_range(3) == 0)
                cfg_write(CFG_INDEX_BITS'($urandom_range(int'(REG_ENVELOPE_LENGTH) + 1,
                          2 ** CFG_INDEX_BITS - 1)), CFG_DATA_BITS'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                smp  = gen_sample();
                rsmp = (burst_left > 0) ? ~smp : SAMPLE_BITS'($urandom);
                send_sample(smp, rsmp);
            end
            wait_idle();
        end
    endtask

    initial begin
        filter_reset();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_reference_mode();
        test_length_limits();
        test_mode_toggle();
        test_random_traffic();
        if (mismatch_count == 0 && pending_envelopes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
